/* hw/rtl/tpfs_pkg.sv */
package tpfs_pkg;

  localparam int TIME_BITS     = 16;
  localparam int FRACTION_BITS = 16;
  localparam int ELAPSED_BITS  = TIME_BITS + 2;
  localparam int FRAC_W        = FRACTION_BITS + 1;
  localparam int CFG_INDEX_W   = 2;

  localparam logic [FRAC_W-1:0] FRAC_ONE = FRAC_W'(1) << FRACTION_BITS;

  typedef logic [1:0] action_t;
  localparam action_t ACT_START   = 2'd0;
  localparam action_t ACT_ADVANCE = 2'd1;
  localparam action_t ACT_RESET   = 2'd2;

  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
  localparam cfg_index_t REG_OUT_TIME  = 2'd0;
  localparam cfg_index_t REG_HOLD_TIME = 2'd1;
  localparam cfg_index_t REG_IN_TIME   = 2'd2;

  localparam logic [TIME_BITS-1:0] OUT_TIME_RESET  = TIME_BITS'(500);
  localparam logic [TIME_BITS-1:0] HOLD_TIME_RESET = TIME_BITS'(0);
  localparam logic [TIME_BITS-1:0] IN_TIME_RESET   = TIME_BITS'(500);

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_OUT  = 3'd1,
    PH_HOLD = 3'd2,
    PH_IN   = 3'd3,
    PH_DONE = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEP,
    ST_SORT,
    ST_DIV,
    ST_SEND
  } state_t;

  typedef struct packed {
    action_t                action;
    logic [TIME_BITS-1:0]   step_time;
  } cmd_item_t;

  typedef struct packed {
    phase_t                 phase;
    logic [FRAC_W-1:0]      phase_fraction;
    logic [FRAC_W-1:0]      overall_fraction;
    logic                   started_mark;
    logic                   midpoint_mark;
    logic                   completed_mark;
  } res_item_t;

endpackage

/* hw/rtl/three_phase_fade_sequencer.sv */
// Channel  Direction  Handshake                  Payload
// cmd      in         cmd_valid / cmd_ready      cmd (action, step_time)
// res      out        res_valid / res_ready      res (phase, fractions, marks)
// cfg      in         cfg_we                     cfg_index, cfg_data
//
// An item is accepted only in the idle state; its result is valid after the time
// update, phase sort, one quotient bit per cycle in two parallel bit-serial dividers
// plus their registered done flag, and result load.
// The next item can be accepted in the cycle after the result loads.
// rst is synchronous; it restores the register defaults and the idle phase.
// A result waiting on res_ready holds the next item in its result load step,
// and no further item is accepted until that result leaves.
module three_phase_fade_sequencer (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cmd_valid,
  output logic                    cmd_ready,
  input  tpfs_pkg::cmd_item_t     cmd,
  output logic                    res_valid,
  input  logic                    res_ready,
  output tpfs_pkg::res_item_t     res,
  input  logic                    cfg_we,
  input  tpfs_pkg::cfg_index_t    cfg_index,
  input  logic [tpfs_pkg::TIME_BITS-1:0] cfg_data
);

  import tpfs_pkg::*;

  state_t state, state_next;

  logic [TIME_BITS-1:0]    out_time, hold_time, in_time;
  phase_t                  phase_reg;
  logic [ELAPSED_BITS-1:0] elapsed;
  logic [FRAC_W-1:0]       progress;
  logic                    mid_seen;

  action_t                 act;
  logic [TIME_BITS-1:0]    step;
  logic                    adv;
  logic                    pdiv_use;
  logic                    started, midpoint, completed;
  logic [ELAPSED_BITS-1:0] b1, b2, total;

  logic                    div_start;
  logic                    load_res;

  logic [ELAPSED_BITS:0]   sum;
  logic [ELAPSED_BITS-1:0] elapsed_sat;
  logic                    running;

  phase_t                  sort_phase;
  logic [ELAPSED_BITS-1:0] pnum, pden;

  logic                    pdiv_done, odiv_done;
  logic [FRAC_W-1:0]       pquot, oquot;
  logic [FRAC_W-1:0]       overall;

  assign sum         = {1'b0, elapsed} + (ELAPSED_BITS + 1)'(step);
  assign elapsed_sat = sum[ELAPSED_BITS] ? '1 : sum[ELAPSED_BITS-1:0];
  assign running     = (phase_reg != PH_IDLE) && (phase_reg != PH_DONE);

  always_comb begin
    if (elapsed < b1) begin
      sort_phase = PH_OUT;
      pnum       = elapsed;
      pden       = ELAPSED_BITS'(out_time);
    end else if (elapsed < b2) begin
      sort_phase = PH_HOLD;
      pnum       = elapsed - b1;
      pden       = ELAPSED_BITS'(hold_time);
    end else if (elapsed < total) begin
      sort_phase = PH_IN;
      pnum       = elapsed - b2;
      pden       = ELAPSED_BITS'(in_time);
    end else begin
      sort_phase = PH_DONE;
      pnum       = elapsed;
      pden       = ELAPSED_BITS'(in_time);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd_ready  = 1'b0;
    div_start  = 1'b0;
    load_res   = 1'b0;
    case (state)
      ST_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          state_next = ST_STEP;
        end
      end
      ST_STEP: begin
        state_next = ST_SORT;
      end
      ST_SORT: begin
        div_start  = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (odiv_done) begin
          state_next = ST_SEND;
        end
      end
      ST_SEND: begin
        if (!res_valid || res_ready) begin
          load_res   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_time  <= OUT_TIME_RESET;
      hold_time <= HOLD_TIME_RESET;
      in_time   <= IN_TIME_RESET;
      phase_reg <= PH_IDLE;
      elapsed   <= '0;
      progress  <= '0;
      mid_seen  <= 1'b0;
      adv       <= 1'b0;
      pdiv_use  <= 1'b0;
      started   <= 1'b0;
      midpoint  <= 1'b0;
      completed <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_OUT_TIME:  out_time  <= cfg_data;
          REG_HOLD_TIME: hold_time <= cfg_data;
          REG_IN_TIME:   in_time   <= cfg_data;
          default: ;
        endcase
      end
      case (state)
        ST_IDLE: begin
          if (cmd_valid) begin
            act  <= cmd.action;
            step <= cmd.step_time;
          end
        end
        ST_STEP: begin
          started   <= (act == ACT_START);
          midpoint  <= 1'b0;
          completed <= 1'b0;
          adv       <= 1'b0;
          b1        <= ELAPSED_BITS'(out_time);
          b2        <= ELAPSED_BITS'(out_time) + ELAPSED_BITS'(hold_time);
          total     <= ELAPSED_BITS'(out_time) + ELAPSED_BITS'(hold_time)
                       + ELAPSED_BITS'(in_time);
          if (act == ACT_START) begin
            elapsed   <= '0;
            progress  <= '0;
            mid_seen  <= 1'b0;
            phase_reg <= PH_OUT;
          end else if (act == ACT_RESET) begin
            elapsed   <= '0;
            progress  <= '0;
            mid_seen  <= 1'b0;
            phase_reg <= PH_IDLE;
          end else if ((act == ACT_ADVANCE) && running) begin
            elapsed <= elapsed_sat;
            adv     <= 1'b1;
          end
        end
        ST_SORT: begin
          pdiv_use <= adv && (sort_phase != PH_DONE);
          if (adv) begin
            phase_reg <= sort_phase;
            if (sort_phase == PH_DONE) begin
              progress  <= FRAC_ONE;
              completed <= 1'b1;
            end else if ((sort_phase == PH_HOLD || sort_phase == PH_IN) && !mid_seen) begin
              mid_seen <= 1'b1;
              midpoint <= 1'b1;
            end
          end
        end
        ST_SEND: begin
          if (load_res && pdiv_use) begin
            progress <= pquot;
          end
        end
        default: ;
      endcase
    end
  end

  tpfs_div #(
    .NUM_BITS  (ELAPSED_BITS),
    .FRAC_BITS (FRACTION_BITS)
  ) u_phase_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (pnum),
    .den   (pden),
    .done  (pdiv_done),
    .quot  (pquot)
  );

  tpfs_div #(
    .NUM_BITS  (ELAPSED_BITS),
    .FRAC_BITS (FRACTION_BITS)
  ) u_overall_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (elapsed),
    .den   (total),
    .done  (odiv_done),
    .quot  (oquot)
  );

  // zero total length: 1.0 only once complete
  always_comb begin
    if (total == '0) begin
      overall = (phase_reg == PH_DONE) ? FRAC_ONE : '0;
    end else begin
      overall = oquot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load_res) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_res) begin
      res.phase            <= phase_reg;
      res.phase_fraction   <= (pdiv_use && pdiv_done == 1'b0) ? pquot :
                              (pdiv_use ? pquot : progress);
      res.overall_fraction <= overall;
      res.started_mark     <= started;
      res.midpoint_mark    <= midpoint;
      res.completed_mark   <= completed;
    end
  end

endmodule

/* hw/rtl/tpfs_div.sv */
module tpfs_div #(
  parameter int NUM_BITS  = 18,
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [NUM_BITS-1:0]  num,
  input  logic [NUM_BITS-1:0]  den,
  output logic                 done,
  output logic [FRAC_BITS:0]   quot
);

  localparam int CNT_W = $clog2(FRAC_BITS + 1);

  logic [CNT_W-1:0]     cnt;
  logic [NUM_BITS-1:0]  rem;
  logic [NUM_BITS-1:0]  dsr;
  logic [FRAC_BITS-1:0] q;
  logic                 sat;
  logic [NUM_BITS:0]    rem2;
  logic [NUM_BITS:0]    diff;
  logic                 ge;

  // restoring division, one quotient bit per cycle; num >= den clamps to 1.0
  assign rem2 = {rem, 1'b0};
  assign diff = rem2 - {1'b0, dsr};
  assign ge   = rem2 >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= (cnt == CNT_W'(1));
      if (start) begin
        cnt <= CNT_W'(FRAC_BITS);
      end else if (cnt != '0) begin
        cnt <= cnt - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= num;
      dsr <= den;
      sat <= (num >= den);
      q   <= '0;
    end else if (cnt != '0) begin
      rem <= ge ? diff[NUM_BITS-1:0] : rem2[NUM_BITS-1:0];
      q   <= {q[FRAC_BITS-2:0], ge};
    end
  end

  assign quot = sat ? {1'b1, {FRAC_BITS{1'b0}}} : {1'b0, q};

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import tpfs_pkg::*;

  localparam action_t ACT_UNUSED = 2'd3;
  localparam int QUIET_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 25;
  localparam int HOLDOFF_AT = 400;
  localparam int HOLDOFF_CYCLES = 300;
  localparam longint unsigned ELAPSED_MAX = (64'd1 << ELAPSED_BITS) - 1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_ready;
  cmd_item_t cmd = '0;
  logic res_valid;
  logic res_ready = 1'b0;
  res_item_t res;
  logic cfg_we = 1'b0;
  cfg_index_t cfg_index = REG_OUT_TIME;
  logic [TIME_BITS-1:0] cfg_data = '0;

  // shadow of the timing registers and the fade state
  logic [TIME_BITS-1:0] out_len = OUT_TIME_RESET;
  logic [TIME_BITS-1:0] hold_len = HOLD_TIME_RESET;
  logic [TIME_BITS-1:0] in_len = IN_TIME_RESET;
  phase_t fade_phase = PH_IDLE;
  logic [ELAPSED_BITS-1:0] fade_elapsed = '0;
  logic [FRAC_W-1:0] fade_progress = '0;
  logic midpoint_seen = 1'b0;

  cmd_item_t cmd_pending[$];
  res_item_t fade_expected[$];
  int err_count = 0;
  int res_total = 0;
  int hold_left = 0;
  int quiet = 0;
  bit steady = 1'b0;

  three_phase_fade_sequencer dut (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd(cmd),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res(res),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic logic [FRAC_W-1:0] fixed_ratio(longint unsigned num,
                                                    longint unsigned den);
    longint unsigned q;
    if (den == 0) return FRAC_ONE;
    q = (num << FRACTION_BITS) / den;
    return (q > FRAC_ONE) ? FRAC_ONE : q[FRAC_W-1:0];
  endfunction

  function automatic logic [FRAC_W-1:0] overall_progress();
    longint unsigned total;
    total = out_len + hold_len + in_len;
    if (total == 0) return (fade_phase == PH_DONE) ? FRAC_ONE : '0;
    return fixed_ratio(fade_elapsed, total);
  endfunction

  function automatic res_item_t fade_predict(cmd_item_t c);
    res_item_t r;
    longint unsigned b1, b2, b3, t;
    r = '0;
    case (c.action)
      ACT_START: begin
        fade_elapsed = '0;
        fade_progress = '0;
        midpoint_seen = 1'b0;
        fade_phase = PH_OUT;
        r.started_mark = 1'b1;
      end
      ACT_RESET: begin
        fade_phase = PH_IDLE;
        fade_elapsed = '0;
        fade_progress = '0;
        midpoint_seen = 1'b0;
      end
      ACT_ADVANCE: begin
        if (fade_phase != PH_IDLE && fade_phase != PH_DONE) begin
          b1 = out_len;
          b2 = b1 + hold_len;
          b3 = b2 + in_len;
          t = fade_elapsed + c.step_time;
          if (t > ELAPSED_MAX) t = ELAPSED_MAX;
          fade_elapsed = t[ELAPSED_BITS-1:0];
          if (t < b1) begin
            fade_phase = PH_OUT;
            fade_progress = fixed_ratio(t, out_len);
          end else if (t < b2) begin
            fade_phase = PH_HOLD;
            fade_progress = fixed_ratio(t - b1, hold_len);
            r.midpoint_mark = !midpoint_seen;
            midpoint_seen = 1'b1;
          end else if (t < b3) begin
            fade_phase = PH_IN;
            fade_progress = fixed_ratio(t - b2, in_len);
            r.midpoint_mark = !midpoint_seen;
            midpoint_seen = 1'b1;
          end else begin
            fade_phase = PH_DONE;
            fade_progress = FRAC_ONE;
            r.completed_mark = 1'b1;
          end
        end
      end
      default: ;
    endcase
    r.phase = fade_phase;
    r.phase_fraction = fade_progress;
    r.overall_fraction = overall_progress();
    return r;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    err_count++;
    if (err_count <= 40)
      $display("mismatch %s at result %0d: got %0d, want %0d", what, res_total, got, want);
  endtask

  task automatic check_result(res_item_t got, res_item_t want);
    if (got.phase !== want.phase) report_mismatch("phase", got.phase, want.phase);
    if (got.phase_fraction !== want.phase_fraction)
      report_mismatch("phase_fraction", got.phase_fraction, want.phase_fraction);
    if (got.overall_fraction !== want.overall_fraction)
      report_mismatch("overall_fraction", got.overall_fraction, want.overall_fraction);
    if (got.started_mark !== want.started_mark)
      report_mismatch("started_mark", got.started_mark, want.started_mark);
    if (got.midpoint_mark !== want.midpoint_mark)
      report_mismatch("midpoint_mark", got.midpoint_mark, want.midpoint_mark);
    if (got.completed_mark !== want.completed_mark)
      report_mismatch("completed_mark", got.completed_mark, want.completed_mark);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else begin
      if (cmd_valid && cmd_ready) fade_expected.push_back(fade_predict(cmd));
      if (!cmd_valid || cmd_ready) begin
        if (cmd_pending.size() > 0 && (steady || $urandom_range(99) >= 38)) begin
          cmd <= cmd_pending.pop_front();
          cmd_valid <= 1'b1;
        end else begin
          cmd_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      res_ready <= 1'b0;
    end else begin
      if (res_valid && res_ready) begin
        if (fade_expected.size() == 0) report_mismatch("unexpected item", res, 0);
        else check_result(res, fade_expected.pop_front());
        res_total++;
        if (res_total == HOLDOFF_AT) hold_left = HOLDOFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ready <= 1'b0;
      end else begin
        res_ready <= steady || ($urandom_range(99) >= 38);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((cmd_valid && cmd_ready) || (res_valid && res_ready) || cfg_we) begin
        quiet <= 0;
      end else if (quiet == QUIET_LIMIT) begin
        $display("tb_top failed");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

  task automatic add_cmd(action_t a, int unsigned s);
    cmd_item_t c;
    c.action = a;
    c.step_time = s[TIME_BITS-1:0];
    cmd_pending.push_back(c);
  endtask

  function automatic logic [TIME_BITS-1:0] random_step();
    longint unsigned span;
    span = (out_len + hold_len + in_len) / $urandom_range(12, 2);
    if (span > 65535) span = 65535;
    case ($urandom_range(9))
      0: return TIME_BITS'($urandom);
      1: return TIME_BITS'($urandom_range(3));
      default: return TIME_BITS'($urandom_range(span, 0));
    endcase
  endfunction

  task automatic queue_random(int n);
    int unsigned pick;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(99);
      if (pick < 10) add_cmd(ACT_START, $urandom);
      else if (pick < 14) add_cmd(ACT_RESET, $urandom);
      else if (pick < 17) add_cmd(ACT_UNUSED, $urandom);
      else add_cmd(ACT_ADVANCE, random_step());
    end
  endtask

  task automatic settle();
    while (cmd_pending.size() > 0 || cmd_valid || fade_expected.size() > 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(cfg_index_t idx, logic [TIME_BITS-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_OUT_TIME: out_len = val;
      REG_HOLD_TIME: hold_len = val;
      REG_IN_TIME: in_len = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_timing(logic [TIME_BITS-1:0] o, logic [TIME_BITS-1:0] h,
                            logic [TIME_BITS-1:0] i);
    settle();
    write_reg(REG_OUT_TIME, o);
    write_reg(REG_HOLD_TIME, h);
    write_reg(REG_IN_TIME, i);
    @(negedge clk);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset timing: 500 / 0 / 500, hold skipped
    add_cmd(ACT_ADVANCE, 16'hFFFF);
    add_cmd(ACT_UNUSED, 16'h0000);
    add_cmd(ACT_START, 16'hFFFF);
    add_cmd(ACT_ADVANCE, 0);
    add_cmd(ACT_ADVANCE, 250);
    add_cmd(ACT_ADVANCE, 250);
    add_cmd(ACT_UNUSED, 16'hFFFF);
    add_cmd(ACT_ADVANCE, 499);
    add_cmd(ACT_ADVANCE, 1);
    add_cmd(ACT_ADVANCE, 5);
    add_cmd(ACT_START, 0);
    add_cmd(ACT_ADVANCE, 16'hFFFF);
    add_cmd(ACT_RESET, 0);
    add_cmd(ACT_START, 0);
    add_cmd(ACT_ADVANCE, 100);
    add_cmd(ACT_RESET, 16'hFFFF);
    add_cmd(ACT_ADVANCE, 10);

    set_timing(0, 100, 0);
    add_cmd(ACT_START, 0);
    add_cmd(ACT_ADVANCE, 0);
    add_cmd(ACT_ADVANCE, 100);

    set_timing(0, 0, 0);
    add_cmd(ACT_START, 0);
    add_cmd(ACT_ADVANCE, 0);

    set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF);
    add_cmd(ACT_START, 0);
    repeat (3) add_cmd(ACT_ADVANCE, 16'hFFFF);

    set_timing(500, 250, 500);
    queue_random(170);
    set_timing(0, 0, 0);
    queue_random(100);
    set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF);
    queue_random(170);

    settle();
    steady = 1'b1;
    set_timing(1, 0, 16'hFFFF);
    queue_random(170);
    settle();
    steady = 1'b0;

    set_timing(TIME_BITS'($urandom), TIME_BITS'($urandom), TIME_BITS'($urandom));
    queue_random(170);
    set_timing(TIME_BITS'($urandom_range(40)), TIME_BITS'($urandom_range(40)),
               TIME_BITS'($urandom_range(40)));
    queue_random(170);

    settle();
    if (err_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
